@@ hdl/sswake_pkg.sv @@
package sswake_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int ADDR_BITS = 5;

    typedef enum logic [1:0] {
        ACT_START  = 2'd0,
        ACT_MINUTE = 2'd1,
        ACT_FINISH = 2'd2
    } action_t;

    localparam logic [2:0] REG_CONFIRM    = 3'd0;
    localparam logic [2:0] REG_MIN_QUIET  = 3'd1;
    localparam logic [2:0] REG_MORN_START = 3'd2;
    localparam logic [2:0] REG_MORN_END   = 3'd3;
    localparam logic [2:0] REG_TZ         = 3'd4;

    localparam logic [7:0]         CONFIRM_RST    = 8'd10;
    localparam logic [17:0]        MIN_QUIET_RST  = 18'd10800;
    localparam logic [4:0]         MORN_START_RST = 5'd4;
    localparam logic [4:0]         MORN_END_RST   = 5'd12;
    localparam logic signed [10:0] TZ_RST         = 11'sd0;

    localparam logic [15:0] RUN_MAX      = 16'hFFFF;
    localparam logic [5:0]  SECS_PER_MIN = 6'd60;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [16:0] SECS_PER_DAY = 17'd86400;

    // a day is 128 * 675 seconds; time of day = ((t >> 7) mod 675) * 128 + t[6:0]
    localparam logic [9:0]  DAY_Q       = 10'd675;
    localparam logic [25:0] DAY_Q_RECIP = 26'd50903316;
    localparam int          DAY_Q_SHIFT = 35;

endpackage

@@ hdl/step_streak_quiet_wake_scan_unit.sv @@
// channel  | handshake                   | payload
// item     | item_valid / item_ready     | action, time_value, now_time, minute_invalid,
//          |                             | minute_steps
// result   | result_valid / result_ready | wake_found, wake_time
// config   | apb write / read            | paddr, pwdata, prdata
//
// one item per cycle unless a finish item waits on a stalled result
// three pipeline stages p1, p2, p3 work out local time of day; p3 feeds scan state and result
// reset clears the pipeline valids, the scan state and the registers to their defaults
// a stalled result holds in the result register while the stages behind it keep filling
module step_streak_quiet_wake_scan_unit
    import sswake_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic [1:0]           action,
    input  logic [31:0]          time_value,
    input  logic [31:0]          now_time,
    input  logic                 minute_invalid,
    input  logic [15:0]          minute_steps,
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic                 wake_found,
    output logic [31:0]          wake_time,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int TB = TIME_BITS;

    logic [7:0]         confirm_reg;
    logic [17:0]        min_quiet_reg;
    logic [4:0]         morn_start_reg;
    logic [4:0]         morn_end_reg;
    logic signed [10:0] tz_reg;

    logic        p1_v_reg, p2_v_reg, p3_v_reg;
    logic [1:0]  p1_act_reg, p2_act_reg, p3_act_reg;
    logic [31:0] p1_tv_reg, p2_tv_reg, p3_tv_reg;
    logic [31:0] p1_now_reg, p2_now_reg, p3_now_reg;
    logic        p1_stp_reg, p2_stp_reg, p3_stp_reg;
    logic [15:0] p1_qe_reg;
    logic [16:0] p2_tod_reg, p3_tod_reg;
    logic        p3_morn_reg;

    logic        res_v_reg;
    logic        res_found_reg;
    logic [31:0] res_time_reg;

    logic [15:0]   run_len_reg, run_len_next;
    logic [31:0]   run_start_reg, run_start_next;
    logic [16:0]   run_tod_reg, run_tod_next;
    logic [TB-1:0] run_end_reg, run_end_next;
    logic [TB-1:0] prev_end_reg, prev_end_next;
    logic [31:0]   best_quiet_reg, best_quiet_next;
    logic [31:0]   best_wake_reg, best_wake_next;
    logic          best_morn_reg, best_morn_next;
    logic [31:0]   scan_now_reg, scan_now_next;
    logic          past_reg, past_next;

    logic out_free, mv3, rdy3, rdy2;
    logic is_finish;
    logic cfg_wr;

    logic [50:0] q_prod;
    logic [25:0] q_diff;
    logic [10:0] q_rem_raw;
    logic [9:0]  q_rem;
    logic [16:0] tod;

    logic signed [18:0] tz_secs;
    logic [16:0]        morn_lo, morn_hi;
    logic               morning;
    logic               run_morn;

    // handshake chain
    assign pready     = 1'b1;
    assign is_finish  = (p3_act_reg == ACT_FINISH);
    assign out_free   = !res_v_reg || result_ready;
    assign mv3        = p3_v_reg && (!is_finish || out_free);
    assign rdy3       = !p3_v_reg || mv3;
    assign rdy2       = !p2_v_reg || rdy3;
    assign item_ready = !p1_v_reg || rdy2;

    assign result_valid = res_v_reg;
    assign wake_found   = res_found_reg;
    assign wake_time    = res_time_reg;

    // configuration port
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            confirm_reg    <= CONFIRM_RST;
            min_quiet_reg  <= MIN_QUIET_RST;
            morn_start_reg <= MORN_START_RST;
            morn_end_reg   <= MORN_END_RST;
            tz_reg         <= TZ_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[ADDR_BITS-1:2])
                REG_CONFIRM:    confirm_reg    <= pwdata[7:0];
                REG_MIN_QUIET:  min_quiet_reg  <= pwdata[17:0];
                REG_MORN_START: morn_start_reg <= pwdata[4:0];
                REG_MORN_END:   morn_end_reg   <= pwdata[4:0];
                REG_TZ:         tz_reg         <= $signed(pwdata[10:0]);
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[ADDR_BITS-1:2])
            REG_CONFIRM:    prdata = {24'd0, confirm_reg};
            REG_MIN_QUIET:  prdata = {14'd0, min_quiet_reg};
            REG_MORN_START: prdata = {27'd0, morn_start_reg};
            REG_MORN_END:   prdata = {27'd0, morn_end_reg};
            REG_TZ:         prdata = {{21{tz_reg[10]}}, tz_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // stage 1: quotient estimate of (t >> 7) / 675
    assign q_prod = {26'd0, time_value[31:7]} * {25'd0, DAY_Q_RECIP};

    // stage 2: remainder, corrected once, gives utc time of day
    assign q_diff    = {1'b0, p1_tv_reg[31:7]} - ({10'd0, p1_qe_reg} * {16'd0, DAY_Q});
    assign q_rem_raw = q_diff[10:0];
    assign q_rem     = (q_rem_raw >= {1'b0, DAY_Q}) ? 10'(q_rem_raw - {1'b0, DAY_Q})
                                                    : q_rem_raw[9:0];
    assign tod       = {q_rem, p1_tv_reg[6:0]};

    // stage 3: local time of day against the morning window
    function automatic logic in_window(logic [16:0] utc_tod, logic signed [18:0] tz_s,
                                       logic [16:0] lo, logic [16:0] hi);
        logic signed [18:0] lr;
        logic [16:0]        lt;
        lr = $signed({2'b00, utc_tod}) - tz_s;
        if (lr < 19'sd0)
            lt = 17'(lr + $signed({2'b00, SECS_PER_DAY}));
        else if (lr >= $signed({2'b00, SECS_PER_DAY}))
            lt = 17'(lr - $signed({2'b00, SECS_PER_DAY}));
        else
            lt = lr[16:0];
        return (lt >= lo) && (lt < hi);
    endfunction

    assign tz_secs = {{8{tz_reg[10]}}, tz_reg} * $signed({13'd0, SECS_PER_MIN});

    assign morn_lo  = 17'({12'd0, morn_start_reg} * {5'd0, SECS_PER_HOUR});
    assign morn_hi  = 17'({12'd0, morn_end_reg} * {5'd0, SECS_PER_HOUR});
    assign morning  = in_window(p2_tod_reg, tz_secs, morn_lo, morn_hi);
    assign run_morn = in_window(run_tod_reg, tz_secs, morn_lo, morn_hi);

    // pipeline valids and result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg  <= 1'b0;
            p2_v_reg  <= 1'b0;
            p3_v_reg  <= 1'b0;
            res_v_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
                p1_v_reg <= item_valid;
            if (rdy2)
                p2_v_reg <= p1_v_reg;
            if (rdy3)
                p3_v_reg <= p2_v_reg;
            if (out_free)
                res_v_reg <= mv3 && is_finish;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (item_ready)
        begin
            p1_act_reg <= action;
            p1_tv_reg  <= time_value;
            p1_now_reg <= now_time;
            p1_stp_reg <= !minute_invalid && (minute_steps != 16'd0);
            p1_qe_reg  <= q_prod[50:DAY_Q_SHIFT];
        end
        if (rdy2)
        begin
            p2_act_reg <= p1_act_reg;
            p2_tv_reg  <= p1_tv_reg;
            p2_now_reg <= p1_now_reg;
            p2_stp_reg <= p1_stp_reg;
            p2_tod_reg <= tod;
        end
        if (rdy3)
        begin
            p3_act_reg  <= p2_act_reg;
            p3_tv_reg   <= p2_tv_reg;
            p3_now_reg  <= p2_now_reg;
            p3_stp_reg  <= p2_stp_reg;
            p3_tod_reg  <= p2_tod_reg;
            p3_morn_reg <= morning;
        end
        if (mv3 && is_finish)
        begin
            res_found_reg <= (best_wake_reg != 32'd0) && (best_wake_reg < scan_now_reg);
            res_time_reg  <= ((best_wake_reg != 32'd0) && (best_wake_reg < scan_now_reg))
                             ? best_wake_reg : 32'd0;
        end
    end

    // scan state update
    always_comb
    begin
        logic [7:0]    cl;
        logic [TB-1:0] tv_t;
        logic          cont;
        logic [15:0]   new_len;
        logic [31:0]   new_start;
        logic          new_morn;
        logic [16:0]   new_tod;
        logic [TB-1:0] new_end;
        logic          qualify;
        logic [31:0]   quiet;
        logic          better;

        cl        = (confirm_reg == 8'd0) ? 8'd1 : confirm_reg;
        tv_t      = TB'(p3_tv_reg);
        cont      = (run_len_reg != 16'd0) && (run_len_reg != RUN_MAX) && (tv_t == run_end_reg);
        new_len   = cont ? 16'(run_len_reg + 16'd1) : 16'd1;
        new_start = cont ? run_start_reg : p3_tv_reg;
        new_morn  = cont ? run_morn : p3_morn_reg;
        new_tod   = cont ? run_tod_reg : p3_tod_reg;
        new_end   = cont ? TB'(run_end_reg + TB'(SECS_PER_MIN))
                         : TB'(tv_t + TB'(SECS_PER_MIN));
        qualify   = (new_len >= {8'd0, cl}) && (TB'(new_start) >= prev_end_reg);
        quiet     = new_start - prev_end_reg[31:0];
        better    = (quiet > best_quiet_reg)
                 || ((quiet == best_quiet_reg) && new_morn && !best_morn_reg)
                 || ((quiet == best_quiet_reg) && (new_morn == best_morn_reg)
                     && (new_start > best_wake_reg));

        run_len_next    = run_len_reg;
        run_start_next  = run_start_reg;
        run_tod_next    = run_tod_reg;
        run_end_next    = run_end_reg;
        prev_end_next   = prev_end_reg;
        best_quiet_next = best_quiet_reg;
        best_wake_next  = best_wake_reg;
        best_morn_next  = best_morn_reg;
        scan_now_next   = scan_now_reg;
        past_next       = past_reg;

        if (mv3)
        begin
            case (p3_act_reg)
                ACT_START:
                begin
                    run_len_next    = 16'd0;
                    run_start_next  = 32'd0;
                    run_tod_next    = 17'd0;
                    run_end_next    = '0;
                    prev_end_next   = tv_t;
                    best_quiet_next = 32'd0;
                    best_wake_next  = 32'd0;
                    best_morn_next  = 1'b0;
                    scan_now_next   = p3_now_reg;
                    past_next       = 1'b0;
                end
                ACT_MINUTE:
                begin
                    if (!past_reg)
                    begin
                        if (p3_tv_reg >= scan_now_reg)
                            past_next = 1'b1;
                        else if (p3_stp_reg)
                        begin
                            run_len_next   = new_len;
                            run_start_next = new_start;
                            run_tod_next   = new_tod;
                            run_end_next   = new_end;
                            if (qualify && (quiet >= {14'd0, min_quiet_reg}) && better)
                            begin
                                best_quiet_next = quiet;
                                best_wake_next  = new_start;
                                best_morn_next  = new_morn;
                            end
                        end
                        else
                        begin
                            if (run_len_reg >= {8'd0, cl})
                                prev_end_next = run_end_reg;
                            run_len_next = 16'd0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_len_reg    <= 16'd0;
            run_start_reg  <= 32'd0;
            run_tod_reg    <= 17'd0;
            run_end_reg    <= '0;
            prev_end_reg   <= '0;
            best_quiet_reg <= 32'd0;
            best_wake_reg  <= 32'd0;
            best_morn_reg  <= 1'b0;
            scan_now_reg   <= 32'd0;
            past_reg       <= 1'b0;
        end
        else
        begin
            run_len_reg    <= run_len_next;
            run_start_reg  <= run_start_next;
            run_tod_reg    <= run_tod_next;
            run_end_reg    <= run_end_next;
            prev_end_reg   <= prev_end_next;
            best_quiet_reg <= best_quiet_next;
            best_wake_reg  <= best_wake_next;
            best_morn_reg  <= best_morn_next;
            scan_now_reg   <= scan_now_next;
            past_reg       <= past_next;
        end
    end

endmodule

@@ hdl/sswake_checker.sv @@
module sswake_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_ready,
    input logic        wake_found,
    input logic [31:0] wake_time,
    input logic        pready
);

    // stalled result item holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(wake_found)
                                          && $stable(wake_time))
        else $error("result item changed while stalled");

    a_found_time: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && wake_found |-> wake_time != 32'd0)
        else $error("wake found with zero wake time");

    a_none_time: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !wake_found |-> wake_time == 32'd0)
        else $error("no wake found but wake time nonzero");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind step_streak_quiet_wake_scan_unit sswake_checker u_sswake_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .wake_found   (wake_found),
    .wake_time    (wake_time),
    .pready       (pready)
);

@@ verif/step_streak_quiet_wake_scan_unit_tb.sv @@
`timescale 1ns / 1ps

module step_streak_quiet_wake_scan_unit_tb;
    import sswake_pkg::*;

    localparam int RUN_LIMIT = 400000;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int LONG_MINUTES = 300;

    typedef struct {
        logic        found;
        logic [31:0] wtime;
    } wake_report_t;

    class wake_tracker;
        logic [7:0]         confirm_min = CONFIRM_RST;
        logic [17:0]        quiet_floor = MIN_QUIET_RST;
        logic [4:0]         morn_lo = MORN_START_RST;
        logic [4:0]         morn_hi = MORN_END_RST;
        logic signed [10:0] tz_min = TZ_RST;

        logic [15:0] streak_len = '0;
        logic [31:0] streak_begin = '0;
        logic [31:0] prior_end = '0;
        logic [31:0] top_quiet = '0;
        logic [31:0] top_wake = '0;
        logic        top_morning = 1'b0;
        logic [31:0] latched_now = '0;
        logic        beyond_now = 1'b0;

        wake_report_t pending_wakes[$];
        int errors = 0;

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_CONFIRM:    confirm_min = val[7:0];
                REG_MIN_QUIET:  quiet_floor = val[17:0];
                REG_MORN_START: morn_lo = val[4:0];
                REG_MORN_END:   morn_hi = val[4:0];
                REG_TZ:         tz_min = val[10:0];
                default: ;
            endcase
        endfunction

        function bit is_morning(logic [31:0] utc);
            longint day_s, off, offm, tod, hr, lo, hi, u;
            day_s = SECS_PER_DAY;
            u = utc;
            lo = morn_lo;
            hi = morn_hi;
            off = tz_min;
            off = off * 60;
            offm = ((off % day_s) + day_s) % day_s;
            tod = ((u % day_s) + day_s - offm) % day_s;
            hr = tod / 3600;
            return (hr >= lo) && (hr < hi);
        endfunction

        function void note_item(logic [1:0] act, logic [31:0] tv, logic [31:0] nt,
                                logic inv, logic [15:0] st);
            logic [15:0]  need;
            logic [31:0]  nxt;
            logic [31:0]  quiet;
            logic         morning;
            logic         better;
            wake_report_t rep;
            need = (confirm_min == 8'd0) ? 16'd1 : {8'd0, confirm_min};
            case (act)
                ACT_START:
                begin
                    streak_len = '0;
                    streak_begin = '0;
                    top_quiet = '0;
                    top_wake = '0;
                    top_morning = 1'b0;
                    beyond_now = 1'b0;
                    prior_end = tv;
                    latched_now = nt;
                end
                ACT_MINUTE:
                begin
                    if (!beyond_now)
                    begin
                        if (tv >= latched_now)
                            beyond_now = 1'b1;
                        else if (!inv && st != 16'd0)
                        begin
                            nxt = streak_begin + {16'd0, streak_len} * SECS_PER_MIN;
                            if (streak_len != 16'd0 && streak_len != RUN_MAX && tv == nxt)
                                streak_len = streak_len + 16'd1;
                            else
                            begin
                                streak_len = 16'd1;
                                streak_begin = tv;
                            end
                            if (streak_len >= need && streak_begin >= prior_end)
                            begin
                                quiet = streak_begin - prior_end;
                                morning = is_morning(streak_begin);
                                better = (quiet > top_quiet)
                                    || (quiet == top_quiet && morning && !top_morning)
                                    || (quiet == top_quiet && morning == top_morning
                                        && streak_begin > top_wake);
                                if (quiet >= {14'd0, quiet_floor} && better)
                                begin
                                    top_quiet = quiet;
                                    top_wake = streak_begin;
                                    top_morning = morning;
                                end
                            end
                        end
                        else
                        begin
                            if (streak_len >= need)
                                prior_end = streak_begin + {16'd0, streak_len} * SECS_PER_MIN;
                            streak_len = '0;
                        end
                    end
                end
                ACT_FINISH:
                begin
                    rep.found = (top_wake != 32'd0) && (top_wake < latched_now);
                    rep.wtime = rep.found ? top_wake : 32'd0;
                    pending_wakes.push_back(rep);
                end
                default: ;
            endcase
        endfunction

        function void check_wake(logic found, logic [31:0] wt);
            wake_report_t rep;
            if (pending_wakes.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual found %b time %h",
                         $time, found, wt);
                errors++;
                return;
            end
            rep = pending_wakes.pop_front();
            if (found !== rep.found)
            begin
                $display("%0t: wake_found expected %b actual %b", $time, rep.found, found);
                errors++;
            end
            if (wt !== rep.wtime)
            begin
                $display("%0t: wake_time expected %h actual %h", $time, rep.wtime, wt);
                errors++;
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_ready;
    logic [1:0]           action = ACT_START;
    logic [31:0]          time_value = '0;
    logic [31:0]          now_time = '0;
    logic                 minute_invalid = 1'b0;
    logic [15:0]          minute_steps = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    logic                 wake_found;
    logic [31:0]          wake_time;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    wake_tracker board = new();

    int          cycles = 0;
    int          fed = 0;
    int          burst_left = 0;
    int          gap_max = 0;
    int          cfg_need = 10;
    logic [15:0] ready_pat = 16'hFFFF;
    logic [3:0]  pat_pos = '0;

    step_streak_quiet_wake_scan_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .action(action),
        .time_value(time_value),
        .now_time(now_time),
        .minute_invalid(minute_invalid),
        .minute_steps(minute_steps),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .wake_found(wake_found),
        .wake_time(wake_time),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        result_ready <= ready_pat[pat_pos];
        pat_pos <= pat_pos + 4'd1;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            board.check_wake(wake_found, wake_time);
    end

    task automatic send(logic [1:0] act, logic [31:0] tv, logic [31:0] nt,
                        logic inv, logic [15:0] st);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        action <= act;
        time_value <= tv;
        now_time <= nt;
        minute_invalid <= inv;
        minute_steps <= st;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        board.note_item(act, tv, nt, inv, st);
        if (act <= ACT_FINISH)
            fed++;
    endtask

    // drop valid, then hold off until every outstanding result is back
    task automatic drain_results();
        @(negedge clk);
        item_valid <= 1'b0;
        while (board.pending_wakes.size() != 0) @(posedge clk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        logic [31:0] mask;
        case (idx)
            REG_CONFIRM:    mask = 32'h0000_00FF;
            REG_MIN_QUIET:  mask = 32'h0003_FFFF;
            REG_MORN_START: mask = 32'h0000_001F;
            REG_MORN_END:   mask = 32'h0000_001F;
            REG_TZ:         mask = 32'h0000_07FF;
            default:        mask = 32'h0;
        endcase
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        board.set_reg(idx, val);
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (((prdata ^ val) & mask) != 32'h0)
        begin
            $display("%0t: register %0d readback expected %h actual %h",
                     $time, idx, val & mask, prdata & mask);
            board.errors++;
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_setup(int c, int q, int ms, int me, int tz);
        drain_results();
        repeat (12) @(posedge clk);
        reg_write(REG_CONFIRM, c);
        reg_write(REG_MIN_QUIET, q);
        reg_write(REG_MORN_START, ms);
        reg_write(REG_MORN_END, me);
        reg_write(REG_TZ, tz);
        cfg_need = (c == 0) ? 1 : c;
    endtask

    // one scan: start, a few quiet gaps each followed by a stepping run, then finish
    task automatic scan_session();
        logic [31:0] s0, nowv, t;
        int nseg, rl, qn;
        s0 = $urandom_range(32'h4000_0000, 32'hC000_0000);
        if ($urandom_range(0, 7) == 0)
            s0 = $urandom;
        case ($urandom_range(0, 7))
            0: nowv = 32'hFFFF_FFFF;
            1: nowv = $urandom;
            default: nowv = s0 + $urandom_range(3600, 5 * 86400);
        endcase
        send(ACT_START, s0, nowv, 1'($urandom), 16'($urandom));
        t = s0;
        if ($urandom_range(0, 7) == 0)
            t = s0 - $urandom_range(60, 7200);
        nseg = $urandom_range(1, 5);
        for (int g = 0; g < nseg; g++)
        begin
            case ($urandom_range(0, 3))
                0: t = t + 60 * $urandom_range(0, 30);
                1: t = t + 60 * $urandom_range(60, 600);
                2: t = t + 60 * $urandom_range(600, 3000);
                default: t = t + 60 * $urandom_range(2880, 4320);
            endcase
            if ($urandom_range(0, 9) == 0)
                t = t + $urandom_range(1, 59);
            rl = $urandom_range(1, cfg_need + 2);
            for (int i = 0; i < rl; i++)
            begin
                send(ACT_MINUTE, t, $urandom, 1'b0, 16'($urandom_range(1, 65535)));
                case ($urandom_range(0, 29))
                    0: t = t;
                    1: t = t + 60 * $urandom_range(2, 4);
                    default: t = t + 60;
                endcase
            end
            qn = $urandom_range(0, 3);
            for (int i = 0; i < qn; i++)
            begin
                if ($urandom_range(0, 1) == 1)
                    send(ACT_MINUTE, t, $urandom, 1'b1, 16'($urandom));
                else
                    send(ACT_MINUTE, t, $urandom, 1'($urandom), 16'd0);
                t = t + 60;
            end
            if ($urandom_range(0, 5) == 0)
                send(ACT_FINISH, $urandom, $urandom, 1'($urandom), 16'($urandom));
            if ($urandom_range(0, 11) == 0)
                send(2'($urandom_range(0, 3)), $urandom, $urandom, 1'($urandom),
                     16'($urandom));
        end
        send(ACT_FINISH, $urandom, $urandom, 1'($urandom), 16'($urandom));
    endtask

    initial
    begin
        logic [31:0] d0, t;
        int target;
        d0 = 32'd1728000000;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // finish with no scan started, then an unused action
        send(ACT_FINISH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
        send(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);

        apply_setup(1, 3600, 4, 12, 0);
        // tie breaks: morning beats non-morning, then the later start wins
        send(ACT_START, d0, d0 + 2 * 86400, 1'b0, 16'd0);
        send(ACT_MINUTE, d0 + 100, 32'd0, 1'b0, 16'd5);
        send(ACT_MINUTE, d0 + 160, 32'd0, 1'b0, 16'd0);
        send(ACT_MINUTE, d0 + 7360, 32'd0, 1'b0, 16'hFFFF);
        send(ACT_MINUTE, d0 + 7420, 32'd0, 1'b1, 16'd7);
        send(ACT_MINUTE, d0 + 14620, 32'd0, 1'b0, 16'd1);
        send(ACT_MINUTE, d0 + 14680, 32'd0, 1'b0, 16'd0);
        send(ACT_MINUTE, d0 + 21880, 32'd0, 1'b0, 16'd3);
        // run starting before the last end never qualifies
        send(ACT_MINUTE, d0 + 100, 32'd0, 1'b0, 16'd3);
        // minute at now, then one that must be ignored
        send(ACT_MINUTE, d0 + 2 * 86400, 32'd0, 1'b0, 16'd3);
        send(ACT_MINUTE, d0 + 200, 32'd0, 1'b0, 16'd3);
        send(ACT_FINISH, 32'd0, 32'd0, 1'b0, 16'd0);
        // run that wraps past the top of the time range
        send(ACT_START, 32'hFFFF_0000, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
        send(ACT_MINUTE, 32'hFFFF_FFC4, 32'hFFFF_FFFF, 1'b0, 16'd2);
        send(ACT_MINUTE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 16'd2);
        send(ACT_MINUTE, 32'h0000_003C, 32'hFFFF_FFFF, 1'b0, 16'd0);
        send(ACT_MINUTE, 32'h0001_0000, 32'hFFFF_FFFF, 1'b0, 16'd8);
        send(ACT_FINISH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
        send(ACT_START, 32'd0, 32'd0, 1'b0, 16'd0);
        send(ACT_MINUTE, 32'd0, 32'd0, 1'b0, 16'd1);
        send(ACT_FINISH, 32'd0, 32'd0, 1'b0, 16'd0);

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: apply_setup(10, 10800, 4, 12, 0);
                1: apply_setup(1, 0, 0, 24, -840);
                2: apply_setup(0, 172800, 24, 24, 840);
                3: apply_setup(4, 1800, 6, 9, 330);
                default: apply_setup($urandom_range(0, 12), $urandom_range(0, 172800),
                                     $urandom_range(0, 24), $urandom_range(0, 24),
                                     $urandom_range(0, 1680) - 840);
            endcase
            gap_max = (ph == 3) ? 0 : $urandom_range(2, 8);
            ready_pat = (ph == 3) ? 16'hFFFF : (16'($urandom) | 16'h0001);
            if (ph == 4)
                ready_pat = 16'h8001;
            if (ph == 1)
            begin
                // a best start of zero is reported as nothing found
                send(ACT_START, 32'd0, 32'd1000, 1'b0, 16'd0);
                send(ACT_MINUTE, 32'd0, 32'd0, 1'b0, 16'd9);
                send(ACT_FINISH, 32'd0, 32'd0, 1'b0, 16'd0);
            end
            target = fed + ITEMS_PER_PHASE;
            scan_session();
            drain_results();
            while (fed < target)
                scan_session();
        end

        // one unbroken run past the longest confirm length
        apply_setup(255, 0, 5, 20, -300);
        gap_max = 0;
        ready_pat = 16'hFFFF;
        t = 32'h1000_0E10;
        send(ACT_START, 32'h1000_0000, 32'hFFFF_FFFF, 1'b0, 16'd0);
        for (int i = 0; i < LONG_MINUTES; i++)
        begin
            send(ACT_MINUTE, t, 32'd0, 1'b0, 16'($urandom_range(1, 65535)));
            t = t + 60;
            if (i == 149)
                send(ACT_FINISH, 32'd0, 32'd0, 1'b0, 16'd0);
        end
        send(ACT_FINISH, 32'd0, 32'd0, 1'b0, 16'd0);

        drain_results();
        repeat (20) @(posedge clk);
        if (board.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ files.f @@
hdl/sswake_pkg.sv
hdl/step_streak_quiet_wake_scan_unit.sv
hdl/sswake_checker.sv
verif/step_streak_quiet_wake_scan_unit_tb.sv
